// File: hw/rtl/keyboard_scancode_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_top_assert.svh
// Assertion macros used by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_DECODER_TOP_ASSERT_SVH
`define KEYBOARD_SCANCODE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ksd assertion failed");

// Next-cycle implication, disabled during reset.
`define KSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ksd assertion failed");

`endif

// File: hw/rtl/ksd_pkg.sv
// ----------------------------------------------------------------------------
// ksd_pkg
// Scancode constants, key codes and the two set-1 lookup ROMs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ksd_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte SC_PREFIX       = 8'hE0;
    localparam t_byte SC_LSHIFT_MAKE  = 8'h2A;
    localparam t_byte SC_RSHIFT_MAKE  = 8'h36;
    localparam t_byte SC_LSHIFT_BREAK = 8'hAA;
    localparam t_byte SC_RSHIFT_BREAK = 8'hB6;
    localparam t_byte SC_F1           = 8'h3B;
    localparam t_byte SC_F4           = 8'h3E;
    localparam t_byte SC_UP           = 8'h48;
    localparam t_byte SC_DOWN         = 8'h50;
    localparam t_byte SC_LEFT         = 8'h4B;
    localparam t_byte SC_RIGHT        = 8'h4D;
    localparam t_byte SC_ROM_LAST     = 8'd57;

    localparam t_byte KEY_NONE  = 8'd0;
    localparam t_byte KEY_F1    = 8'd128;
    localparam t_byte KEY_F4    = 8'd131;
    localparam t_byte KEY_UP    = 8'd140;
    localparam t_byte KEY_DOWN  = 8'd141;
    localparam t_byte KEY_LEFT  = 8'd142;
    localparam t_byte KEY_RIGHT = 8'd143;

    localparam int RomDepth = 58;

    localparam t_byte ROM_PLAIN [RomDepth] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h2A, 8'h2A,
        8'h36, 8'h20
    };

    localparam t_byte ROM_SHIFTED [RomDepth] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h2A, 8'h2A,
        8'h36, 8'h20
    };

endpackage

// File: hw/rtl/ksd_scan_if.sv
// ----------------------------------------------------------------------------
// ksd_scan_if
// Valid/ready channel carrying one scancode byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ksd_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

// File: hw/rtl/ksd_key_if.sv
// ----------------------------------------------------------------------------
// ksd_key_if
// Valid/ready channel carrying one key code byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ksd_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

// File: hw/rtl/keyboard_scancode_decoder_top.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_top
// Set-1 scancode to key code decoder, one key code word per scancode word.
//
//   channel   dir   payload          notes
//   i_scan    in    scan_byte[7:0]   valid/ready, raw scancode
//   o_key     out   key_code[7:0]    valid/ready, 0 = no key
//
// One word per cycle sustained while o_key.ready stays high; each word passes
// the input register, then the result register, with the decode between them.
// Reset clears both pipeline valids and the shift and prefix flags.
// A stalled result holds; the input register still fills behind it, so one
// more word is taken before i_scan.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyboard_scancode_decoder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ksd_scan_if.sink     i_scan,
    ksd_key_if.source    o_key
);
    import ksd_pkg::*;

    logic  r_s1_valid;
    t_byte r_s1_byte;
    logic  r_out_valid;
    t_byte r_out_key;
    logic  advance;
    t_byte key;

    assign advance      = r_s1_valid && (!r_out_valid || o_key.ready);
    assign i_scan.ready = !r_s1_valid || advance;

    ksd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_scan_byte (r_s1_byte),
        .o_key_code  (key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_scan.ready) begin
                r_s1_valid <= i_scan.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_key.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_s1_byte <= i_scan.scan_byte;
        end
        if (advance) begin
            r_out_key <= key;
        end
    end

    assign o_key.valid    = r_out_valid;
    assign o_key.key_code = r_out_key;
endmodule

// File: hw/rtl/ksd_decode.sv
// ----------------------------------------------------------------------------
// ksd_decode
// Shift / prefix flags and the per-byte key code decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksd_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  ksd_pkg::t_byte i_scan_byte,
    output ksd_pkg::t_byte o_key_code
);
    import ksd_pkg::*;

    logic  r_shift_held;
    logic  r_extended_pending;
    logic  n_shift_held;
    logic  n_extended_pending;
    t_byte key;

    always_comb begin
        n_shift_held       = r_shift_held;
        n_extended_pending = 1'b0;
        key                = KEY_NONE;
        if (r_extended_pending) begin
            unique case (i_scan_byte)
                SC_UP:    key = KEY_UP;
                SC_DOWN:  key = KEY_DOWN;
                SC_LEFT:  key = KEY_LEFT;
                SC_RIGHT: key = KEY_RIGHT;
                default:  key = KEY_NONE;
            endcase
        end else if (i_scan_byte == SC_PREFIX) begin
            n_extended_pending = 1'b1;
        end else if (i_scan_byte == SC_LSHIFT_MAKE || i_scan_byte == SC_RSHIFT_MAKE) begin
            n_shift_held = 1'b1;
        end else if (i_scan_byte == SC_LSHIFT_BREAK || i_scan_byte == SC_RSHIFT_BREAK) begin
            n_shift_held = 1'b0;
        end else if (i_scan_byte[7]) begin
            key = KEY_NONE;
        end else if (i_scan_byte >= SC_F1 && i_scan_byte <= SC_F4) begin
            key = KEY_F1 + (i_scan_byte - SC_F1);
        end else if (i_scan_byte > SC_ROM_LAST) begin
            key = KEY_NONE;
        end else if (r_shift_held) begin
            key = ROM_SHIFTED[i_scan_byte[5:0]];
        end else begin
            key = ROM_PLAIN[i_scan_byte[5:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_held       <= 1'b0;
            r_extended_pending <= 1'b0;
        end else if (i_advance) begin
            r_shift_held       <= n_shift_held;
            r_extended_pending <= n_extended_pending;
        end
    end

    assign o_key_code = key;
endmodule

// File: hw/rtl/ksd_checker.sv
// ----------------------------------------------------------------------------
// ksd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "keyboard_scancode_decoder_top_assert.svh"

module ksd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [7:0] i_in_byte,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_key
);
    import ksd_pkg::*;

    `KSD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_key))
    `KSD_ASSERT_NEXT(a_in_hold, i_in_valid && !i_in_ready, i_in_valid && $stable(i_in_byte))
    `KSD_ASSERT_NOW(a_ready_when_empty, !i_out_valid, i_in_ready)
    `KSD_ASSERT_NOW(a_ready_when_drained, i_out_ready, i_in_ready)
    `KSD_ASSERT_NOW(a_key_range, i_out_valid && i_out_key[7], (i_out_key >= KEY_F1 && i_out_key <= KEY_F4) || (i_out_key >= KEY_UP && i_out_key <= KEY_RIGHT))
endmodule

bind keyboard_scancode_decoder_top ksd_checker u_ksd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_scan.valid),
    .i_in_ready  (i_scan.ready),
    .i_in_byte   (i_scan.scan_byte),
    .i_out_valid (o_key.valid),
    .i_out_ready (o_key.ready),
    .i_out_key   (o_key.key_code)
);
